// ===== rtl/mtfws_pkg.sv =====
// Package for the move-to-front window stack: sizes, command codes and the cell command bundle.
package mtfws_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int ID_BITS     = 16;
  localparam int CNT_BITS    = $clog2(STACK_DEPTH + 1);

  localparam logic [1:0] KIND_OPEN   = 2'd0;
  localparam logic [1:0] KIND_SWITCH = 2'd1;
  localparam logic [1:0] KIND_CLOSE  = 2'd2;

  // Command broadcast to every cell in the row
  typedef struct packed {
    logic               en;
    logic [1:0]         kind;
    logic               full;
    logic [ID_BITS-1:0] id;
  } cmd_t;

endpackage

// ===== rtl/mtfws_cell.sv =====
// One stack slot: holds an identifier and a valid bit, shifts with its neighbors.
module mtfws_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  mtfws_pkg::cmd_t              cmd,
  input  logic [mtfws_pkg::ID_BITS-1:0] up_id,
  input  logic                         up_valid,
  input  logic [mtfws_pkg::ID_BITS-1:0] down_id,
  input  logic                         down_valid,
  input  logic                         hit_in,
  input  logic                         found,
  output logic [mtfws_pkg::ID_BITS-1:0] id,
  output logic                         valid,
  output logic                         hit_out
);
  import mtfws_pkg::*;

  logic hit;

  // match chain: hit_out is set at and below the topmost match
  assign hit     = valid && (id == cmd.id);
  assign hit_out = hit_in | hit;

  // slot identifier
  always_ff @(posedge clk) begin
    if (cmd.en) begin
      case (cmd.kind)
        KIND_OPEN: begin
          if (!cmd.full) id <= up_id;
        end
        KIND_SWITCH: begin
          // slots from the top down to the topmost match rotate by one
          if (found && !hit_in) id <= up_id;
        end
        KIND_CLOSE: begin
          if (hit_out) id <= down_id;
        end
        default: ;
      endcase
    end
  end

  // slot occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.en) begin
      case (cmd.kind)
        KIND_OPEN: begin
          if (!cmd.full) valid <= up_valid;
        end
        KIND_CLOSE: begin
          if (hit_out) valid <= down_valid;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/move_to_front_window_stack_top.sv =====
// Top level of the move-to-front window stack: command intake, cell row, result register.
//
//   channel  signals                                          direction
//   -------  -----------------------------------------------  ---------
//   in       in_valid, in_stall, kind, window_id              command in
//   out      out_valid, out_stall, top_window, stack_empty,   result out
//            entry_count, overflow
//
// One command word per cycle while no result is stalled: every cell compares and shifts
// in the cycle of acceptance. The result word is visible the cycle after; its fields come
// straight from the cell registers, which hold while the result is stalled. A new word is
// taken in the cycle the pending result leaves. Reset clears the valid bits and the count;
// slot ids are not reset.
module move_to_front_window_stack_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [15:0] window_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] top_window,
  output logic        stack_empty,
  output logic [4:0]  entry_count,
  output logic        overflow
);
  import mtfws_pkg::*;

  cmd_t                cmd;
  logic                accept;
  logic                full;
  logic                found;
  logic [CNT_BITS-1:0] count;
  logic [CNT_BITS-1:0] count_next;
  logic [ID_BITS-1:0]  cell_id    [STACK_DEPTH];
  logic [STACK_DEPTH-1:0] cell_valid;
  logic [STACK_DEPTH-1:0] cell_hit;
  logic                overflow_next;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = cell_valid[STACK_DEPTH-1];
  assign found    = cell_hit[STACK_DEPTH-1];

  assign cmd.en   = accept;
  assign cmd.kind = kind;
  assign cmd.full = full;
  assign cmd.id   = ID_BITS'(window_id);

  // row of cells, top of stack at index 0
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [ID_BITS-1:0] up_id, down_id;
    logic               up_valid, down_valid, hit_in;
    if (i == 0) begin : g_first
      assign up_id    = cmd.id;
      assign up_valid = 1'b1;
      assign hit_in   = 1'b0;
    end else begin : g_mid
      assign up_id    = cell_id[i-1];
      assign up_valid = cell_valid[i-1];
      assign hit_in   = cell_hit[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_last
      assign down_id    = cell_id[i];
      assign down_valid = 1'b0;
    end else begin : g_inner
      assign down_id    = cell_id[i+1];
      assign down_valid = cell_valid[i+1];
    end
    mtfws_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .up_id      (up_id),
      .up_valid   (up_valid),
      .down_id    (down_id),
      .down_valid (down_valid),
      .hit_in     (hit_in),
      .found      (found),
      .id         (cell_id[i]),
      .valid      (cell_valid[i]),
      .hit_out    (cell_hit[i])
    );
  end

  // entry count and drop flag
  always_comb begin
    count_next    = count;
    overflow_next = 1'b0;
    case (kind)
      KIND_OPEN: begin
        if (full) overflow_next = 1'b1;
        else      count_next    = count + 1'b1;
      end
      KIND_CLOSE: begin
        if (found) count_next = count - 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      overflow  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count    <= count_next;
        overflow <= overflow_next;
      end
      if (accept)          out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // result fields read from the state registers
  assign stack_empty = !cell_valid[0];
  assign top_window  = cell_valid[0] ? 16'(cell_id[0]) : 16'd0;
  assign entry_count = 5'(count);

  // count tracks the valid cells
  a_count_match: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) == 32'(count))
    else $error("entry count differs from number of valid cells");

  // valid cells form a contiguous run from the top
  a_valid_contig: assert property (@(posedge clk) disable iff (rst)
    ((cell_valid + 1'b1) & cell_valid) == '0)
    else $error("gap in valid cells");

  // a dropped open only ever happens on a full stack
  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    overflow |-> (32'(count) == STACK_DEPTH))
    else $error("overflow reported on a stack that is not full");

  // an accepted word always yields a result next cycle
  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted word gave no result");

endmodule
